FILE: hw/rtl/png565_pkg.sv
package png565_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  // pixel_format codes
  localparam logic [2:0] FMT_TRUECOLOR       = 3'd0;
  localparam logic [2:0] FMT_TRUECOLOR_ALPHA = 3'd1;
  localparam logic [2:0] FMT_GRAY            = 3'd2;
  localparam logic [2:0] FMT_GRAY_ALPHA      = 3'd3;
  localparam logic [2:0] FMT_INDEXED         = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_PIXEL_FORMAT   = 2'd0;
  localparam logic [1:0] CFG_BITS_PER_SAMPLE = 2'd1;
  localparam logic [1:0] CFG_PALETTE_ALPHA  = 2'd2;

  // accepted sample depths
  localparam logic [3:0] BPS_1 = 4'd1;
  localparam logic [3:0] BPS_2 = 4'd2;
  localparam logic [3:0] BPS_4 = 4'd4;
  localparam logic [3:0] BPS_8 = 4'd8;

  // transaction kinds
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [2:0] pixel_format;
    logic [3:0] bits_per_sample;
    logic       palette_alpha_enable;
  } cfg_t;

  // Pick one sample out of a packed byte, most significant sample first.
  function automatic logic [7:0] unpack_sample(input logic [7:0] packed_byte,
                                               input logic [8:0] column,
                                               input logic [3:0] bps);
    logic [7:0] res;
    logic [2:0] pos1;
    logic [1:0] pos2;
    res  = packed_byte;
    pos1 = 3'd7 - column[2:0];
    pos2 = 2'd3 - column[1:0];
    case (bps)
      BPS_1:   res = {7'd0, packed_byte[pos1]};
      BPS_2:   res = {6'd0, packed_byte[{pos2, 1'b0} +: 2]};
      BPS_4:   res = {4'd0, (column[0] ? packed_byte[3:0] : packed_byte[7:4])};
      default: res = packed_byte;
    endcase
    return res;
  endfunction

  // v * 255 / (2^bps - 1) is plain bit replication
  function automatic logic [7:0] scale_gray(input logic [7:0] v, input logic [3:0] bps);
    logic [7:0] res;
    res = v;
    case (bps)
      BPS_1:   res = v[0] ? 8'hFF : 8'h00;
      BPS_2:   res = {v[1:0], v[1:0], v[1:0], v[1:0]};
      BPS_4:   res = {v[3:0], v[3:0]};
      default: res = v;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: hw/rtl/png565_cfg.sv
module png565_cfg
  import png565_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [3:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PIXEL_FORMAT: cfg_nxt.pixel_format = wr_data[2:0];
        CFG_BITS_PER_SAMPLE: begin
          // unsupported depths leave the register alone
          if (wr_data == BPS_1 || wr_data == BPS_2 || wr_data == BPS_4 ||
              wr_data == BPS_8) begin
            cfg_nxt.bits_per_sample = wr_data;
          end
        end
        CFG_PALETTE_ALPHA: cfg_nxt.palette_alpha_enable = wr_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format         <= FMT_TRUECOLOR;
      cfg_r.bits_per_sample      <= BPS_8;
      cfg_r.palette_alpha_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  a_bps_legal: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(cfg_r.bits_per_sample))
    else $error("bits_per_sample holds an unsupported depth");

endmodule

FILE: hw/rtl/png565_palette.sv
module png565_palette
  import png565_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  localparam int AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [PALETTE_ENTRIES];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/png_pixel_to_rgb565_alpha_top.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | mode, byte_a..byte_d, pixel_column, palette_slot
// out_    | output    | out_valid/out_ready  | color565, alpha_out, format_ok
// cfg_    | input     | cfg_valid/cfg_ready  | cfg_index (0..2), cfg_data
//
// Three register stages (unpack, palette read / gray scale, pack); one
// transaction per cycle while out_ready is high. The palette RAM port
// sets the middle stage. Palette writes retire in stage one with no result.
// Synchronous active-low reset clears valid bits and config; the palette is
// not cleared. out_ready low stalls stages back to in_ready, nothing lost.
module png_pixel_to_rgb565_alpha_top
  import png565_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_byte_a,
  input  logic [7:0]  in_byte_b,
  input  logic [7:0]  in_byte_c,
  input  logic [7:0]  in_byte_d,
  input  logic [8:0]  in_pixel_column,
  input  logic [7:0]  in_palette_slot,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_color565,
  output logic [7:0]  out_alpha_out,
  output logic        out_format_ok,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  cfg_t cfg;

  png565_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  // stage 1: captured transaction with unpacked sample
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [7:0] s1_slot_r;
  logic [7:0] s1_sample_r;

  // stage 2: palette entry and scaled gray
  logic       s2_valid_r;
  logic [7:0] s2_a_r, s2_b_r, s2_c_r, s2_d_r;
  logic [7:0] s2_gray_r;
  logic       s2_idx_ok_r;

  // stage 3: output register
  logic        out_valid_r;
  logic [15:0] out_color565_r;
  logic [7:0]  out_alpha_r;
  logic        out_ok_r;

  logic s1_go, s2_go, s2_ready;

  assign s2_go    = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_ready = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r   <= in_mode;
      s1_a_r      <= in_byte_a;
      s1_b_r      <= in_byte_b;
      s1_c_r      <= in_byte_c;
      s1_d_r      <= in_byte_d;
      s1_slot_r   <= in_palette_slot;
      s1_sample_r <= unpack_sample(in_byte_a, in_pixel_column, cfg.bits_per_sample);
    end
  end

  // palette writes and reads both happen as stage 1 moves on, so order holds
  logic        pal_wr_en, pal_rd_en;
  logic [31:0] pal_rd_data;
  logic        slot_ok, sample_ok;

  assign slot_ok   = {1'b0, s1_slot_r} < 9'(PALETTE_ENTRIES);
  assign sample_ok = {1'b0, s1_sample_r} < 9'(PALETTE_ENTRIES);
  assign pal_wr_en = s1_go && (s1_mode_r == MODE_PALETTE) && slot_ok;
  assign pal_rd_en = s1_go && (s1_mode_r == MODE_PIXEL);

  png565_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (s1_slot_r[AW-1:0]),
    .wr_data ({s1_a_r, s1_b_r, s1_c_r, s1_d_r}),
    .rd_en   (pal_rd_en),
    .rd_addr (s1_sample_r[AW-1:0]),
    .rd_data (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_go && (s1_mode_r == MODE_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (pal_rd_en) begin
      s2_a_r      <= s1_a_r;
      s2_b_r      <= s1_b_r;
      s2_c_r      <= s1_c_r;
      s2_d_r      <= s1_d_r;
      s2_gray_r   <= scale_gray(s1_sample_r, cfg.bits_per_sample);
      s2_idx_ok_r <= sample_ok;
    end
  end

  // stage 3 selection
  logic [31:0] pal_entry;
  logic [7:0]  red, green, blue, alpha;
  logic        fmt_ok;
  logic [15:0] color565_nxt;
  logic [7:0]  alpha_nxt;

  assign pal_entry = s2_idx_ok_r ? pal_rd_data : 32'd0;

  always_comb begin
    red    = s2_a_r;
    green  = s2_b_r;
    blue   = s2_c_r;
    alpha  = ALPHA_OPAQUE;
    fmt_ok = 1'b1;
    case (cfg.pixel_format)
      FMT_TRUECOLOR: alpha = ALPHA_OPAQUE;
      FMT_TRUECOLOR_ALPHA: alpha = s2_d_r;
      FMT_GRAY: begin
        red   = s2_gray_r;
        green = s2_gray_r;
        blue  = s2_gray_r;
      end
      FMT_GRAY_ALPHA: begin
        red   = s2_a_r;
        green = s2_a_r;
        blue  = s2_a_r;
        alpha = s2_b_r;
      end
      FMT_INDEXED: begin
        red   = pal_entry[31:24];
        green = pal_entry[23:16];
        blue  = pal_entry[15:8];
        alpha = cfg.palette_alpha_enable ? pal_entry[7:0] : ALPHA_OPAQUE;
      end
      default: begin
        fmt_ok = 1'b0;
        alpha  = 8'd0;
      end
    endcase
    if (fmt_ok && alpha != 8'd0) begin
      color565_nxt = to565(red, green, blue);
      alpha_nxt    = alpha;
    end else begin
      color565_nxt = 16'd0;
      alpha_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_color565_r <= color565_nxt;
      out_alpha_r    <= alpha_nxt;
      out_ok_r       <= fmt_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_color565  = out_color565_r;
  assign out_alpha_out = out_alpha_r;
  assign out_format_ok = out_ok_r;

  a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_format_ok |-> out_color565 == 16'd0 && out_alpha_out == 8'd0)
    else $error("unsupported format produced nonzero pixel");

  a_transparent_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha_out == 8'd0 |-> out_color565 == 16'd0)
    else $error("zero alpha with nonzero color");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_go |=> s2_valid_r && $stable(s2_gray_r) && $stable(pal_rd_data))
    else $error("stage 2 lost or changed a stalled pixel");

  a_palette_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pal_wr_en |=> !(s2_valid_r && $past(s2_ready)))
    else $error("palette write produced a result");

endmodule

FILE: tb/tb.sv
module tb;
  import png565_pkg::*;

  localparam int ITEM_TARGET    = 1600;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SQUEEZE_CYCLES = 120;
  localparam int PRINT_CAP      = 40;

  // directed row kinds
  localparam logic [1:0] ROW_PIXEL   = 2'd0;
  localparam logic [1:0] ROW_PALETTE = 2'd1;
  localparam logic [1:0] ROW_CFG     = 2'd2;

  // register index with nothing behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        ok;
  } px_out_t;

  typedef struct packed {
    logic [1:0] act;
    logic [1:0] reg_idx;
    logic [3:0] reg_val;
    logic [7:0] a, b, c, d;
    logic [8:0] column;
    logic [7:0] slot;
    logic       known;
    px_out_t    want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [7:0]  in_byte_a;
  logic [7:0]  in_byte_b;
  logic [7:0]  in_byte_c;
  logic [7:0]  in_byte_d;
  logic [8:0]  in_pixel_column;
  logic [7:0]  in_palette_slot;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_color565;
  logic [7:0]  out_alpha_out;
  logic        out_format_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  png_pixel_to_rgb565_alpha_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_byte_a       (in_byte_a),
    .in_byte_b       (in_byte_b),
    .in_byte_c       (in_byte_c),
    .in_byte_d       (in_byte_d),
    .in_pixel_column (in_pixel_column),
    .in_palette_slot (in_palette_slot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color565    (out_color565),
    .out_alpha_out   (out_alpha_out),
    .out_format_ok   (out_format_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // shadow of the block's registers and palette
  logic [2:0]  fmt_q;
  logic [3:0]  bps_q;
  logic        pae_q;
  logic [31:0] pal_shadow [0:255];

  px_out_t  pixel_results[$];
  dir_row_t dir_rows[$];

  logic    row_known;
  px_out_t row_want;
  logic    calm;
  logic    squeeze_req;
  int      mismatches;
  int      issued;

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t FAIL %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // sample at bit depth bps_q, most significant sample first
  function automatic logic [7:0] pick_sample(input logic [7:0] packed_byte,
                                             input logic [8:0] column);
    int per_byte;
    int pos;
    int shift;
    if (bps_q == BPS_8) return packed_byte;
    per_byte = 8 / bps_q;
    pos      = column % per_byte;
    shift    = 8 - bps_q * (pos + 1);
    return (packed_byte >> shift) & ((8'd1 << bps_q) - 8'd1);
  endfunction

  function automatic px_out_t convert_pixel(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d,
                                            input logic [8:0] column);
    px_out_t     res;
    logic [7:0]  r, g, bl, al;
    logic [31:0] entry;
    int          lvl;
    logic        supported;
    supported = 1'b1;
    r = '0; g = '0; bl = '0; al = '0;
    case (fmt_q)
      FMT_TRUECOLOR: begin
        r = a; g = b; bl = c; al = ALPHA_OPAQUE;
      end
      FMT_TRUECOLOR_ALPHA: begin
        r = a; g = b; bl = c; al = d;
      end
      FMT_GRAY: begin
        lvl = int'(pick_sample(a, column));
        r = 8'(lvl * 255 / ((1 << bps_q) - 1));
        g = r; bl = r; al = ALPHA_OPAQUE;
      end
      FMT_GRAY_ALPHA: begin
        r = a; g = a; bl = a; al = b;
      end
      FMT_INDEXED: begin
        entry = pal_shadow[pick_sample(a, column)];
        r = entry[31:24]; g = entry[23:16]; bl = entry[15:8];
        al = pae_q ? entry[7:0] : ALPHA_OPAQUE;
      end
      default: supported = 1'b0;
    endcase
    res.ok = supported;
    if (supported && al != 8'd0) begin
      res.color = {r[7:3], g[7:2], bl[7:3]};
      res.alpha = al;
    end else begin
      res.color = '0;
      res.alpha = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch_ports
    px_out_t got;
    px_out_t head;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_color565, out_alpha_out, out_format_ok};
        if (pixel_results.size() == 0) begin
          report_mismatch("unexpected result", int'(got), 0);
        end else begin
          head = pixel_results.pop_front();
          if (got.color != head.color)
            report_mismatch("color565", int'(got.color), int'(head.color));
          if (got.alpha != head.alpha)
            report_mismatch("alpha_out", int'(got.alpha), int'(head.alpha));
          if (got.ok != head.ok)
            report_mismatch("format_ok", int'(got.ok), int'(head.ok));
        end
      end
      if (in_valid && in_ready) begin
        if (in_mode == MODE_PALETTE)
          pal_shadow[in_palette_slot] = {in_byte_a, in_byte_b, in_byte_c, in_byte_d};
        else if (row_known)
          pixel_results.push_back(row_want);
        else
          pixel_results.push_back(convert_pixel(in_byte_a, in_byte_b, in_byte_c, in_byte_d,
                                                in_pixel_column));
      end
    end
  end

  // result side: mostly ready, short stalls, now and then a long one
  initial begin : drain_side
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready   = 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        n = $urandom_range(0, 99);
        n = (n < 70) ? $urandom_range(1, 2) : (n < 95) ? $urandom_range(3, 8)
                                                       : $urandom_range(20, 50);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // returns at the edge that accepts the transaction; valid is left high
  task automatic send_item(input logic mode, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d,
                           input logic [8:0] column, input logic [7:0] slot,
                           input logic known, input px_out_t want);
    @(negedge clk);
    in_valid        = 1'b1;
    in_mode         = mode;
    in_byte_a       = a;
    in_byte_b       = b;
    in_byte_c       = c;
    in_byte_d       = d;
    in_pixel_column = column;
    in_palette_slot = slot;
    row_known       = known;
    row_want        = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PIXEL_FORMAT: fmt_q = val[2:0];
      CFG_BITS_PER_SAMPLE:
        if (val == BPS_1 || val == BPS_2 || val == BPS_4 || val == BPS_8) bps_q = val;
      CFG_PALETTE_ALPHA: pae_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [3:0] val);
    dir_row_t row;
    row         = '0;
    row.act     = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t px_row(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d,
                                      input logic [8:0] column);
    dir_row_t row;
    row        = '0;
    row.act    = ROW_PIXEL;
    row.a      = a;
    row.b      = b;
    row.c      = c;
    row.d      = d;
    row.column = column;
    return row;
  endfunction

  function automatic dir_row_t px_known(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [8:0] column, input px_out_t want);
    dir_row_t row;
    row       = px_row(a, b, c, d, column);
    row.known = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic dir_row_t pal_row(input logic [7:0] slot, input logic [31:0] entry);
    dir_row_t row;
    row      = '0;
    row.act  = ROW_PALETTE;
    row.slot = slot;
    {row.a, row.b, row.c, row.d} = entry;
    return row;
  endfunction

  initial begin : stimulus
    int         phase;
    int         batch;
    logic [7:0] a, b, c, d;
    logic [2:0] fmt;
    logic [3:0] bps;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_PIXEL;
    in_byte_a       = '0;
    in_byte_b       = '0;
    in_byte_c       = '0;
    in_byte_d       = '0;
    in_pixel_column = '0;
    in_palette_slot = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    row_known       = 1'b0;
    row_want        = '0;
    calm            = 1'b0;
    squeeze_req     = 1'b0;
    mismatches      = 0;
    issued          = 0;
    fmt_q           = FMT_TRUECOLOR;
    bps_q           = BPS_8;
    pae_q           = 1'b0;

    // reset defaults: truecolor, 8 bits, opaque palette
    dir_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, 8'h00, 9'd0, {16'hFFFF, 8'hFF, 1'b1}));
    dir_rows.push_back(px_known(8'h00, 8'h00, 8'h00, 8'h00, 9'd0, {16'h0000, 8'hFF, 1'b1}));
    dir_rows.push_back(px_row(8'h84, 8'h06, 8'h0F, 8'h5A, 9'd319));
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, {1'b0, FMT_TRUECOLOR_ALPHA}));
    // transparent pixel blanks the color
    dir_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, 8'h00, 9'd0, {16'h0000, 8'h00, 1'b1}));
    dir_rows.push_back(px_row(8'h12, 8'h34, 8'h56, 8'h01, 9'd100));
    dir_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd0, {16'hFFFF, 8'hFF, 1'b1}));
    // gray+alpha ignores the sample depth
    dir_rows.push_back(cfg_row(CFG_BITS_PER_SAMPLE, BPS_1));
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, {1'b0, FMT_GRAY_ALPHA}));
    dir_rows.push_back(px_row(8'h6D, 8'h80, 8'h00, 8'h00, 9'd3));
    dir_rows.push_back(px_known(8'hFF, 8'h00, 8'hFF, 8'hFF, 9'd0, {16'h0000, 8'h00, 1'b1}));
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, {1'b0, FMT_GRAY}));
    dir_rows.push_back(px_known(8'h80, 8'h00, 8'h00, 8'h00, 9'd0, {16'hFFFF, 8'hFF, 1'b1}));
    dir_rows.push_back(px_known(8'h80, 8'h00, 8'h00, 8'h00, 9'd1, {16'h0000, 8'hFF, 1'b1}));
    dir_rows.push_back(px_known(8'h01, 8'h00, 8'h00, 8'h00, 9'd319, {16'hFFFF, 8'hFF, 1'b1}));
    // depth of 3 is refused, depth stays at 1
    dir_rows.push_back(cfg_row(CFG_BITS_PER_SAMPLE, 4'd3));
    dir_rows.push_back(px_known(8'h01, 8'h00, 8'h00, 8'h00, 9'd7, {16'hFFFF, 8'hFF, 1'b1}));
    dir_rows.push_back(cfg_row(CFG_BITS_PER_SAMPLE, BPS_2));
    dir_rows.push_back(px_row(8'hE4, 8'h00, 8'h00, 8'h00, 9'd1));
    dir_rows.push_back(px_row(8'hE4, 8'h00, 8'h00, 8'h00, 9'd318));
    dir_rows.push_back(cfg_row(CFG_BITS_PER_SAMPLE, BPS_4));
    dir_rows.push_back(px_row(8'hA5, 8'h00, 8'h00, 8'h00, 9'd1));
    dir_rows.push_back(px_row(8'hA5, 8'h00, 8'h00, 8'h00, 9'd256));
    dir_rows.push_back(pal_row(8'h00, 32'h1020_3000));
    dir_rows.push_back(pal_row(8'hFF, 32'hFFFF_FFFF));
    dir_rows.push_back(pal_row(8'h5A, 32'hF8FC_F880));
    dir_rows.push_back(cfg_row(CFG_BITS_PER_SAMPLE, BPS_8));
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, {1'b0, FMT_INDEXED}));
    dir_rows.push_back(px_known(8'hFF, 8'h00, 8'h00, 8'h00, 9'd0, {16'hFFFF, 8'hFF, 1'b1}));
    dir_rows.push_back(px_row(8'h00, 8'h00, 8'h00, 8'h00, 9'd5));
    dir_rows.push_back(cfg_row(CFG_PALETTE_ALPHA, 4'd1));
    dir_rows.push_back(px_known(8'h00, 8'h00, 8'h00, 8'h00, 9'd0, {16'h0000, 8'h00, 1'b1}));
    dir_rows.push_back(px_row(8'h5A, 8'h00, 8'h00, 8'h00, 9'd2));
    dir_rows.push_back(px_known(8'hFF, 8'h00, 8'h00, 8'h00, 9'd0, {16'hFFFF, 8'hFF, 1'b1}));
    // unsupported formats
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, 4'd5));
    dir_rows.push_back(px_known(8'h12, 8'h34, 8'h56, 8'h78, 9'd9, {16'h0000, 8'h00, 1'b0}));
    dir_rows.push_back(cfg_row(CFG_PIXEL_FORMAT, 4'd7));
    dir_rows.push_back(cfg_row(CFG_SPARE, 4'hF));
    dir_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd0, {16'h0000, 8'h00, 1'b0}));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].act)
        ROW_CFG: write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        default: begin
          send_item(dir_rows[i].act == ROW_PALETTE ? MODE_PALETTE : MODE_PIXEL,
                    dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].d,
                    dir_rows[i].column, dir_rows[i].slot, dir_rows[i].known,
                    dir_rows[i].want);
          idle_in(pick_gap());
        end
      endcase
    end

    // fill every palette entry so no indexed pixel reads an unwritten one
    for (int s = 0; s < 256; s++) begin
      d = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(0, 255));
      send_item(MODE_PALETTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), d, 9'($urandom_range(0, 319)), 8'(s),
                1'b0, '0);
      idle_in(pick_gap());
    end

    phase = 0;
    while (issued < ITEM_TARGET) begin
      if (phase < 16) fmt = 3'(phase % 8);
      else fmt = 3'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 4)
                                                 : $urandom_range(5, 7));
      write_reg(CFG_PIXEL_FORMAT, {1'($urandom_range(0, 1)), fmt});
      // now and then an arbitrary depth first, often refused, then a legal one
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_BITS_PER_SAMPLE, 4'($urandom_range(0, 15)));
      case (phase < 4 ? phase : $urandom_range(0, 3))
        0:       bps = BPS_1;
        1:       bps = BPS_2;
        2:       bps = BPS_4;
        default: bps = BPS_8;
      endcase
      write_reg(CFG_BITS_PER_SAMPLE, bps);
      write_reg(CFG_PALETTE_ALPHA, 4'($urandom_range(0, 15)));

      calm = (phase % 6 == 2) || (phase == 4);
      if (phase == 4) squeeze_req = 1'b1;
      batch = (phase == 4) ? 150 : $urandom_range(30, 90);
      repeat (batch) begin
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 99) < 15) d = 8'd0;
          send_item(MODE_PALETTE, a, b, c, d, 9'($urandom_range(0, 319)),
                    8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          if ($urandom_range(0, 9) == 0) b = 8'd0;
          if ($urandom_range(0, 9) == 0) d = 8'd0;
          send_item(MODE_PIXEL, a, b, c, d, 9'($urandom_range(0, 319)),
                    8'($urandom_range(0, 255)), 1'b0, '0);
        end
        idle_in(pick_gap());
      end
      calm = 1'b0;
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_results.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
